@@ hdl/a2r_pkg.sv @@
// Package for the four-quadrant arctangent block: fixed-point constants,
// small packed types and the Q28 rounding helper shared by the back end.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package a2r_pkg;

    localparam int QF = 28;

    localparam logic signed [31:0] K1 = -32'sd13502777;
    localparam logic signed [31:0] K2 = -32'sd1876051545;
    localparam logic signed [31:0] K3 = 32'sd84;
    localparam logic signed [31:0] K4 = 32'sd763554907;
    localparam logic signed [31:0] K5 = 32'sd221835003;
    localparam logic signed [31:0] K6 = 32'sd39487906;
    localparam logic signed [31:0] K7 = 32'sd172997006;
    localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
    localparam logic signed [31:0] PI_Q = 32'sd843314857;
    localparam logic signed [31:0] ONE_Q = 32'sd268435456;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    // Octant information that travels alongside every item.
    typedef struct packed {
        logic swap;
        logic xneg;
        logic yneg;
    } a2r_flags_t;

    typedef struct packed {
        logic       zero;
        a2r_flags_t flags;
    } a2r_rside_t;

    // Q28 by Q28 product back to Q28, half away from zero. All products in
    // this block fit 32 bits after the shift.
    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] sum;
        neg = p[63];
        mag = neg ? (64'd0 - p) : p;
        sum = mag + (64'd1 << (QF - 1));
        qround = neg ? (32'sd0 - $signed(sum[QF+31:QF])) : $signed(sum[QF+31:QF]);
    endfunction

endpackage
`default_nettype wire

@@ hdl/a2r_if.sv @@
// Stream channel interfaces for the arctangent block: the (y, x) input
// channel and the angle result channel. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface a2r_in_if #(parameter int IN_WIDTH = 16);
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] y_value;
    logic signed [IN_WIDTH-1:0] x_value;

    modport source (output valid, output y_value, output x_value, input ready);
    modport sink (input valid, input y_value, input x_value, output ready);
endinterface

interface a2r_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink (input valid, input angle, output ready);
endinterface
`default_nettype wire

@@ hdl/a2r_front.sv @@
// Front end: takes (y, x) transfers, forms magnitudes and octant flags.
// Depends on a2r_pkg and a2r_in_if.
`timescale 1ns / 1ps
`default_nettype none
module a2r_front #(
    parameter int IN_WIDTH = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    a2r_in_if.sink               sample,
    output logic                 q_valid,
    input  wire logic            q_ready,
    output logic [IN_WIDTH-1:0]  q_mn,
    output logic [IN_WIDTH-1:0]  q_mx,
    output a2r_pkg::a2r_flags_t  q_flags
);

    logic                valid_reg;
    logic [IN_WIDTH-1:0] mn_reg;
    logic [IN_WIDTH-1:0] mx_reg;
    a2r_pkg::a2r_flags_t flags_reg;
    logic [IN_WIDTH-1:0] ay;
    logic [IN_WIDTH-1:0] ax;
    logic                take;

    // Two's complement negation also gives the most negative value's
    // magnitude exactly when read as unsigned.
    assign ay = sample.y_value[IN_WIDTH-1] ? (~sample.y_value + 1'b1) : sample.y_value;
    assign ax = sample.x_value[IN_WIDTH-1] ? (~sample.x_value + 1'b1) : sample.x_value;

    assign sample.ready = !valid_reg || q_ready;
    assign take = sample.valid && sample.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mn_reg <= (ay > ax) ? ax : ay;
            mx_reg <= (ay > ax) ? ay : ax;
            flags_reg.swap <= ay > ax;
            flags_reg.xneg <= sample.x_value[IN_WIDTH-1];
            flags_reg.yneg <= sample.y_value[IN_WIDTH-1];
        end
    end

    assign q_valid = valid_reg;
    assign q_mn = mn_reg;
    assign q_mx = mx_reg;
    assign q_flags = flags_reg;

endmodule
`default_nettype wire

@@ hdl/a2r_queue.sv @@
// Short FIFO that decouples the front end from the back end.
// Depends on a2r_pkg.
`timescale 1ns / 1ps
`default_nettype none
module a2r_queue #(
    parameter int W = 35
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [W-1:0]      out_data
);

    logic [W-1:0]                  mem_reg [0:a2r_pkg::QUEUE_DEPTH-1];
    logic [a2r_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [a2r_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [a2r_pkg::QUEUE_AW:0]    count_reg;
    logic                          push;
    logic                          pop;

    assign in_ready = count_reg != (a2r_pkg::QUEUE_AW + 1)'(a2r_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (a2r_pkg::QUEUE_AW + 1)'(a2r_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[a2r_pkg::QUEUE_AW-1:0] == (wr_ptr_reg - rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

@@ hdl/a2r_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module a2r_div #(
    parameter int N_W = 16,
    parameter int Q_W = 17,
    parameter int S_W = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire logic [N_W-1:0] in_rem,
    input  wire logic [Q_W-1:0] in_low,
    input  wire logic [N_W-1:0] in_den,
    input  wire logic [S_W-1:0] in_side,
    output logic                out_valid,
    output logic [Q_W-1:0]      out_quot,
    output logic [S_W-1:0]      out_side
);

    // Stage 0 holds the loaded item; stage i has produced i quotient bits.
    // lq holds the remaining dividend bits at the top and quotient bits below.
    logic           valid_reg [0:Q_W];
    logic [N_W-1:0] rem_reg   [0:Q_W];
    logic [Q_W-1:0] lq_reg    [0:Q_W];
    logic [N_W-1:0] den_reg   [0:Q_W];
    logic [S_W-1:0] side_reg  [0:Q_W];
    logic [N_W:0]   trial     [1:Q_W];
    logic [N_W:0]   diff      [1:Q_W];
    logic [N_W-1:0] rem_next  [1:Q_W];
    logic [Q_W-1:0] lq_next   [1:Q_W];

    always_comb
    begin
        for (int i = 1; i <= Q_W; i++)
        begin
            trial[i] = {rem_reg[i-1], lq_reg[i-1][Q_W-1]};
            diff[i] = trial[i] - {1'b0, den_reg[i-1]};
            rem_next[i] = diff[i][N_W] ? trial[i][N_W-1:0] : diff[i][N_W-1:0];
            lq_next[i] = {lq_reg[i-1][Q_W-2:0], !diff[i][N_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= Q_W; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= Q_W; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= in_rem;
            lq_reg[0] <= in_low;
            den_reg[0] <= in_den;
            side_reg[0] <= in_side;
            for (int i = 1; i <= Q_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                lq_reg[i] <= lq_next[i];
                den_reg[i] <= den_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[Q_W];
    assign out_quot = lq_reg[Q_W];
    assign out_side = side_reg[Q_W];

endmodule
`default_nettype wire

@@ hdl/a2r_back.sv @@
// Back end: ratio division, rational polynomial, second division, octant
// fold, rounding and the output register. Depends on a2r_pkg and a2r_div.
`timescale 1ns / 1ps
`default_nettype none
module a2r_back #(
    parameter int IN_WIDTH = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [IN_WIDTH-1:0] in_mn,
    input  wire logic [IN_WIDTH-1:0] in_mx,
    input  a2r_pkg::a2r_flags_t      in_flags,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [15:0]       out_angle
);

    localparam int DW1 = IN_WIDTH + 17;
    localparam int RQ_W = 17;
    localparam int SQ_W = 29;
    localparam int DW2 = 61;
    localparam int SHIFT = a2r_pkg::QF - ANGLE_FRAC_BITS;
    localparam logic [32:0] ROUND_HALF = (33'd1 << SHIFT) >> 1;

    logic en;
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    // Ratio division: round((mn << 16) / mx), half up.
    logic [DW1-1:0]     d1;
    a2r_pkg::a2r_rside_t side_in;
    logic               r_valid;
    logic [RQ_W-1:0]    r_quot;
    a2r_pkg::a2r_rside_t r_side;

    assign d1 = {in_mn, 16'd0} + DW1'(in_mx >> 1);
    assign side_in.zero = in_mx == '0;
    assign side_in.flags = in_flags;

    a2r_div #(.N_W(IN_WIDTH), .Q_W(RQ_W), .S_W($bits(a2r_pkg::a2r_rside_t))) u_rdiv (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(in_valid),
        .in_rem(d1[DW1-1:RQ_W]),
        .in_low(d1[RQ_W-1:0]),
        .in_den(in_mx),
        .in_side(side_in),
        .out_valid(r_valid),
        .out_quot(r_quot),
        .out_side(r_side)
    );

    logic signed [31:0] r_q28;
    assign r_q28 = r_side.zero ? 32'sd0
                               : $signed(32'(r_quot) << (a2r_pkg::QF - 16));

    // Polynomial stages, a register after each multiplication.
    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    a2r_pkg::a2r_flags_t f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, f6_reg;
    logic signed [63:0]  p_rsq1_reg, p_t1_reg, p_k5_1_reg, p_k6_1_reg;
    logic signed [31:0]  r1_reg, r2_reg;
    logic signed [31:0]  rsq2_reg, t1_2_reg, k5r2_reg, k6r2_reg;
    logic signed [63:0]  p_t2_3_reg, p_k7_3_reg;
    logic signed [31:0]  q3_reg, denp3_reg;
    logic signed [31:0]  t2_4_reg, q4_reg, den4_reg;
    logic signed [63:0]  p_num5_reg;
    logic signed [31:0]  den5_reg;
    logic [31:0]         num6_reg, den6_reg;
    logic signed [31:0]  k2r, k3r, num5r;

    assign k2r = a2r_pkg::K2 + r_q28;
    assign k3r = a2r_pkg::K3 + r2_reg;
    assign num5r = a2r_pkg::qround(p_num5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= r_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_rsq1_reg <= r_q28 * r_q28;
            p_t1_reg <= a2r_pkg::K1 * k2r;
            p_k5_1_reg <= a2r_pkg::K5 * r_q28;
            p_k6_1_reg <= a2r_pkg::K6 * r_q28;
            r1_reg <= r_q28;
            f1_reg <= r_side.flags;

            rsq2_reg <= a2r_pkg::qround(p_rsq1_reg);
            t1_2_reg <= a2r_pkg::qround(p_t1_reg);
            k5r2_reg <= a2r_pkg::qround(p_k5_1_reg);
            k6r2_reg <= a2r_pkg::qround(p_k6_1_reg);
            r2_reg <= r1_reg;
            f2_reg <= f1_reg;

            p_t2_3_reg <= t1_2_reg * k3r;
            p_k7_3_reg <= a2r_pkg::K7 * rsq2_reg;
            q3_reg <= a2r_pkg::K4 + k5r2_reg + rsq2_reg;
            denp3_reg <= a2r_pkg::ONE_Q + k6r2_reg;
            f3_reg <= f2_reg;

            t2_4_reg <= a2r_pkg::qround(p_t2_3_reg);
            q4_reg <= q3_reg;
            den4_reg <= denp3_reg + a2r_pkg::qround(p_k7_3_reg);
            f4_reg <= f3_reg;

            p_num5_reg <= t2_4_reg * q4_reg;
            den5_reg <= den4_reg;
            f5_reg <= f4_reg;

            // A negative numerator is taken as zero.
            num6_reg <= num5r[31] ? 32'd0 : num5r;
            den6_reg <= den5_reg;
            f6_reg <= f5_reg;
        end
    end

    // Quotient division: round((num << 28) / den), half up.
    logic [DW2-1:0]      d2;
    logic                s_valid;
    logic [SQ_W-1:0]     s_quot;
    a2r_pkg::a2r_flags_t s_flags;

    assign d2 = {1'b0, num6_reg, 28'd0} + DW2'(den6_reg >> 1);

    a2r_div #(.N_W(32), .Q_W(SQ_W), .S_W($bits(a2r_pkg::a2r_flags_t))) u_qdiv (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(v6_reg),
        .in_rem(d2[DW2-1:SQ_W]),
        .in_low(d2[SQ_W-1:0]),
        .in_den(den6_reg),
        .in_side(f6_reg),
        .out_valid(s_valid),
        .out_quot(s_quot),
        .out_side(s_flags)
    );

    // Octant fold.
    logic signed [31:0] fold_a, fold_b, fold_c;
    logic               fold_valid_reg;
    logic signed [31:0] fold_reg;

    always_comb
    begin
        fold_a = $signed(32'(s_quot));
        fold_b = s_flags.swap ? (a2r_pkg::HALF_PI_Q - fold_a) : fold_a;
        fold_c = s_flags.xneg ? (a2r_pkg::PI_Q - fold_b) : fold_b;
        if (s_flags.yneg)
        begin
            fold_c = 32'sd0 - fold_c;
        end
    end

    // Rounding to the output scale, half away from zero, then saturation.
    logic        rnd_neg;
    logic [31:0] rnd_mag;
    logic [32:0] rnd_sum;
    logic [32:0] rnd_q;
    logic [15:0] rnd_sat;
    logic [15:0] angle_next;
    logic        out_valid_reg;
    logic [15:0] angle_reg;

    always_comb
    begin
        rnd_neg = fold_reg[31];
        rnd_mag = rnd_neg ? (32'd0 - fold_reg) : fold_reg;
        rnd_sum = {1'b0, rnd_mag} + ROUND_HALF;
        rnd_q = rnd_sum >> SHIFT;
        if (!rnd_neg && rnd_q > 33'd32767)
        begin
            rnd_sat = 16'd32767;
        end
        else if (rnd_neg && rnd_q > 33'd32768)
        begin
            rnd_sat = 16'd32768;
        end
        else
        begin
            rnd_sat = rnd_q[15:0];
        end
        angle_next = rnd_neg ? (16'd0 - rnd_sat) : rnd_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            fold_valid_reg <= s_valid;
            out_valid_reg <= fold_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_reg <= fold_c;
            angle_reg <= angle_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_angle = $signed(angle_reg);

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(fold_valid_reg) && $stable(v6_reg))
        else $error("back pipeline moved while stalled");
    a_den_positive: assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg |-> (!den6_reg[31] && den6_reg != 32'd0))
        else $error("denominator not positive");

endmodule
`default_nettype wire

@@ hdl/atan2_rational_approx.sv @@
// Throughput: one item per cycle while the result channel is not stalled;
// the two dividers retire one quotient bit per stage and are fully pipelined,
// so a new item can enter every cycle.
// Reset: rst_n clears all valid bits, queue pointers and counts at once;
// payload registers are not reset and there is no clearing pass.
// Depends on a2r_pkg, a2r_if, a2r_front, a2r_queue and a2r_back.
`timescale 1ns / 1ps
`default_nettype none
module atan2_rational_approx #(
    parameter int IN_WIDTH = 16,
    parameter int ANGLE_FRAC_BITS = 13
) (
    input  wire logic clk,
    input  wire logic rst_n,
    a2r_in_if.sink    sample,
    a2r_out_if.source result
);

    // The front end classifies each transfer into magnitudes and octant
    // flags. A four-entry queue lets the front keep taking transfers while
    // the back end is held by a stalled result channel.
    localparam int QW = 2 * IN_WIDTH + $bits(a2r_pkg::a2r_flags_t);

    logic                fq_valid;
    logic                fq_ready;
    logic [IN_WIDTH-1:0] fq_mn;
    logic [IN_WIDTH-1:0] fq_mx;
    a2r_pkg::a2r_flags_t fq_flags;
    logic                qb_valid;
    logic                qb_ready;
    logic [QW-1:0]       qb_data;
    logic [IN_WIDTH-1:0] qb_mn;
    logic [IN_WIDTH-1:0] qb_mx;
    a2r_pkg::a2r_flags_t qb_flags;

    a2r_front #(.IN_WIDTH(IN_WIDTH)) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .sample(sample),
        .q_valid(fq_valid),
        .q_ready(fq_ready),
        .q_mn(fq_mn),
        .q_mx(fq_mx),
        .q_flags(fq_flags)
    );

    a2r_queue #(.W(QW)) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(fq_valid),
        .in_ready(fq_ready),
        .in_data({fq_flags, fq_mn, fq_mx}),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_data(qb_data)
    );

    assign qb_flags = qb_data[QW-1 -: $bits(a2r_pkg::a2r_flags_t)];
    assign qb_mn = qb_data[2*IN_WIDTH-1:IN_WIDTH];
    assign qb_mx = qb_data[IN_WIDTH-1:0];

    // The back end advances as a whole whenever its output register is
    // empty or being drained by the consumer.
    a2r_back #(.IN_WIDTH(IN_WIDTH), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(qb_valid),
        .in_ready(qb_ready),
        .in_mn(qb_mn),
        .in_mx(qb_mx),
        .in_flags(qb_flags),
        .out_valid(result.valid),
        .out_ready(result.ready),
        .out_angle(result.angle)
    );

    a_queue_when_front_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fq_valid && !fq_ready) |-> qb_valid)
        else $error("queue reports full while empty");

endmodule
`default_nettype wire
